FILE: src/ib_pkg.sv
package ib_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int ATAN_LEN     = 40;
    localparam int N_ITER       = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

    localparam int LANES      = 3;
    localparam int LANE_LAT_A = 0;
    localparam int LANE_LAT_B = 1;
    localparam int LANE_DLON  = 2;

    localparam int TURN_W  = 32;
    localparam int MAG_W   = 32;
    localparam int FRAC_W  = 22;
    localparam int NUM_W   = MAG_W + FRAC_W;
    localparam int DIV_PER = 2;
    localparam int DIV_Q_W = 34;
    localparam int DIV_ST  = DIV_Q_W / DIV_PER;
    localparam int REM_W   = 22;

    localparam logic [REM_W-1:0]  DEG_DEN  = 22'd3515625;
    localparam logic [FRAC_W-1:0] HALF_DEN = 22'd1757812;

    localparam int CW      = 34;
    localparam int VW      = 36;
    localparam int NORM_ST = 5;
    localparam int Q_FRAC  = 30;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef logic signed [32:0]       t_sang;
    typedef logic [TURN_W-1:0]        t_turn;
    typedef logic signed [CW-1:0]     t_cq;
    typedef logic signed [VW-1:0]     t_vq;

    typedef struct packed {
        t_cq s;
        t_cq c;
    } t_trig;

    // atan(2^-i), 2^32 = one turn
    function automatic t_turn atan_turn(input int i);
        t_turn v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/ib_if.sv
interface ib_in_if;
    logic               valid;
    logic               ready;
    logic signed [30:0] lat_a;
    logic signed [31:0] lon_a;
    logic signed [30:0] lat_b;
    logic signed [31:0] lon_b;

    modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
    modport sink   (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

interface ib_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] bearing;

    modport source (output valid, bearing, input ready);
    modport sink   (input valid, bearing, output ready);
endinterface

FILE: src/ib_turn_div.sv
module ib_turn_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ce,
    input  logic          i_valid,
    input  ib_pkg::t_sang i_ang [ib_pkg::LANES],
    output logic          o_valid,
    output ib_pkg::t_turn o_turn [ib_pkg::LANES]
);
    import ib_pkg::*;

    localparam int TOP_W = NUM_W - DIV_Q_W;

    logic                 r_v    [DIV_ST+2];
    logic [NUM_W-1:0]     r_num  [DIV_ST][LANES];
    logic                 r_neg  [DIV_ST+1][LANES];
    logic [REM_W-1:0]     r_rem  [DIV_ST+1][LANES];
    logic [DIV_Q_W-1:0]   r_q    [DIV_ST+1][LANES];
    t_turn                r_turn [LANES];

    logic [NUM_W-1:0]     n_num0 [LANES];
    logic                 n_neg0 [LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_ST + 2; i++) r_v[i] <= 1'b0;
        end else if (i_ce) begin
            r_v[0] <= i_valid;
            for (int i = 1; i < DIV_ST + 2; i++) r_v[i] <= r_v[i-1];
        end
    end

    // magnitude, scaled by 2^22, plus half the divisor for rounding
    always_comb begin
        logic [32:0] mag;
        for (int l = 0; l < LANES; l++) begin
            n_neg0[l] = i_ang[l][32];
            mag       = i_ang[l][32] ? 33'(-i_ang[l]) : 33'(i_ang[l]);
            n_num0[l] = {mag[MAG_W-1:0], HALF_DEN};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int l = 0; l < LANES; l++) begin
                r_num[0][l] <= n_num0[l];
                r_neg[0][l] <= n_neg0[l];
                r_rem[0][l] <= {{(REM_W-TOP_W){1'b0}}, n_num0[l][NUM_W-1:DIV_Q_W]};
                r_q[0][l]   <= '0;
            end
        end
    end

    // restoring division by a constant, two quotient bits per stage
    for (genvar s = 1; s <= DIV_ST; s++) begin : g_div
        logic [REM_W-1:0]   n_rem [LANES];
        logic [DIV_Q_W-1:0] n_q   [LANES];

        always_comb begin
            logic [REM_W:0] t;
            for (int l = 0; l < LANES; l++) begin
                n_rem[l] = r_rem[s-1][l];
                n_q[l]   = r_q[s-1][l];
                for (int j = 0; j < DIV_PER; j++) begin
                    t = {n_rem[l], r_num[s-1][l][DIV_Q_W-1-(s-1)*DIV_PER-j]};
                    if (t >= {1'b0, DEG_DEN}) begin
                        n_rem[l] = REM_W'(t - {1'b0, DEG_DEN});
                        n_q[l][DIV_Q_W-1-(s-1)*DIV_PER-j] = 1'b1;
                    end else begin
                        n_rem[l] = t[REM_W-1:0];
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[s] <= n_rem;
                r_q[s]   <= n_q;
                r_neg[s] <= r_neg[s-1];
            end
        end

        if (s < DIV_ST) begin : g_num
            always_ff @(posedge i_clk) begin
                if (i_ce) r_num[s] <= r_num[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int l = 0; l < LANES; l++) begin
                r_turn[l] <= r_neg[DIV_ST][l] ? -r_q[DIV_ST][l][TURN_W-1:0]
                                              :  r_q[DIV_ST][l][TURN_W-1:0];
            end
        end
    end

    assign o_valid = r_v[DIV_ST+1];
    assign o_turn  = r_turn;

endmodule

FILE: src/ib_sincos.sv
module ib_sincos (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ce,
    input  logic          i_valid,
    input  ib_pkg::t_turn i_turn [ib_pkg::LANES],
    output logic          o_valid,
    output ib_pkg::t_trig o_trig [ib_pkg::LANES]
);
    import ib_pkg::*;

    localparam t_cq QUARTER = t_cq'(64'sd1073741824);
    localparam t_cq HALF    = t_cq'(64'sd2147483648);

    logic  r_v    [N_ITER+2];
    t_cq   r_x    [N_ITER+1][LANES];
    t_cq   r_y    [N_ITER+1][LANES];
    t_cq   r_z    [N_ITER][LANES];
    logic  r_flip [N_ITER+1][LANES];
    t_trig r_trig [LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_ITER + 2; i++) r_v[i] <= 1'b0;
        end else if (i_ce) begin
            r_v[0] <= i_valid;
            for (int i = 1; i < N_ITER + 2; i++) r_v[i] <= r_v[i-1];
        end
    end

    // fold into the right half plane
    always_ff @(posedge i_clk) begin
        t_cq  z;
        logic f;
        if (i_ce) begin
            for (int l = 0; l < LANES; l++) begin
                z = t_cq'(signed'(i_turn[l]));
                f = 1'b0;
                if (z > QUARTER) begin
                    z = z - HALF;
                    f = 1'b1;
                end else if (z < -QUARTER) begin
                    z = z + HALF;
                    f = 1'b1;
                end
                r_flip[0][l] <= f;
                r_z[0][l] <= z;
                r_x[0][l] <= CORDIC_GAIN;
                r_y[0][l] <= '0;
            end
        end
    end

    for (genvar g = 0; g < N_ITER; g++) begin : g_rot
        localparam t_cq ATN = t_cq'(atan_turn(g));

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                for (int l = 0; l < LANES; l++) begin
                    if (!r_z[g][l][CW-1]) begin
                        r_x[g+1][l] <= r_x[g][l] - (r_y[g][l] >>> g);
                        r_y[g+1][l] <= r_y[g][l] + (r_x[g][l] >>> g);
                    end else begin
                        r_x[g+1][l] <= r_x[g][l] + (r_y[g][l] >>> g);
                        r_y[g+1][l] <= r_y[g][l] - (r_x[g][l] >>> g);
                    end
                    r_flip[g+1][l] <= r_flip[g][l];
                end
            end
        end

        if (g < N_ITER - 1) begin : g_z
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    for (int l = 0; l < LANES; l++) begin
                        r_z[g+1][l] <= r_z[g][l][CW-1] ? r_z[g][l] + ATN : r_z[g][l] - ATN;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int l = 0; l < LANES; l++) begin
                r_trig[l].s <= r_flip[N_ITER][l] ? -r_y[N_ITER][l] : r_y[N_ITER][l];
                r_trig[l].c <= r_flip[N_ITER][l] ? -r_x[N_ITER][l] : r_x[N_ITER][l];
            end
        end
    end

    assign o_valid = r_v[N_ITER+1];
    assign o_trig  = r_trig;

endmodule

FILE: src/ib_prod.sv
module ib_prod (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ce,
    input  logic          i_valid,
    input  ib_pkg::t_trig i_trig [ib_pkg::LANES],
    output logic          o_valid,
    output ib_pkg::t_cq   o_x,
    output ib_pkg::t_cq   o_y
);
    import ib_pkg::*;

    function automatic t_cq mulq(input t_cq a, input t_cq b);
        logic signed [2*CW-1:0] p;
        p = a * b;
        p = p + ((2*CW)'(1) <<< (Q_FRAC - 1));
        return p[CW+Q_FRAC-1:Q_FRAC];
    endfunction

    logic r_v [3];
    t_cq  r_x1, r_p1, r_p2, r_cd;
    t_cq  r_x2, r_p1b, r_p3;
    t_cq  r_x3, r_y3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) r_v[i] <= 1'b0;
        end else if (i_ce) begin
            r_v[0] <= i_valid;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_x1  <= mulq(i_trig[LANE_LAT_B].c, i_trig[LANE_DLON].s);
            r_p1  <= mulq(i_trig[LANE_LAT_A].c, i_trig[LANE_LAT_B].s);
            r_p2  <= mulq(i_trig[LANE_LAT_A].s, i_trig[LANE_LAT_B].c);
            r_cd  <= i_trig[LANE_DLON].c;
            r_x2  <= r_x1;
            r_p1b <= r_p1;
            r_p3  <= mulq(r_p2, r_cd);
            r_x3  <= r_x2;
            r_y3  <= r_p1b - r_p3;
        end
    end

    assign o_valid = r_v[2];
    assign o_x     = r_x3;
    assign o_y     = r_y3;

endmodule

FILE: src/ib_atan.sv
module ib_atan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_ce,
    input  logic               i_valid,
    input  ib_pkg::t_cq        i_x,
    input  ib_pkg::t_cq        i_y,
    output logic               o_valid,
    output logic signed [31:0] o_bearing
);
    import ib_pkg::*;

    localparam int VSTART = NORM_ST;
    localparam int LAST   = NORM_ST + N_ITER + 3;
    localparam int NW     = VW + 16;
    localparam logic signed [NW-1:0] QNW = NW'(64'sd1073741824);
    localparam t_cq HALF = t_cq'(64'sd2147483648);

    logic             r_v    [LAST+1];
    logic             r_zero [LAST];
    t_vq              r_x    [NORM_ST+N_ITER];
    t_vq              r_y    [NORM_ST+N_ITER];
    t_cq              r_z    [NORM_ST+N_ITER+1];
    logic             r_neg  [2];
    logic [MAG_W-1:0] r_mag;
    logic [NUM_W-1:0] r_prod;
    logic signed [31:0] r_bearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= LAST; i++) r_v[i] <= 1'b0;
        end else if (i_ce) begin
            r_v[0] <= i_valid;
            for (int i = 1; i <= LAST; i++) r_v[i] <= r_v[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            for (int i = 1; i < LAST; i++) r_zero[i] <= r_zero[i-1];
        end
    end

    // north component onto the positive axis
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            if (i_y[CW-1]) begin
                r_x[0] <= -t_vq'(i_y);
                r_y[0] <= -t_vq'(i_x);
                r_z[0] <= HALF;
            end else begin
                r_x[0] <= t_vq'(i_y);
                r_y[0] <= t_vq'(i_x);
                r_z[0] <= '0;
            end
        end
    end

    // scale up until the larger magnitude reaches 2^30
    for (genvar g = 0; g < NORM_ST; g++) begin : g_norm
        localparam int K = 1 << (NORM_ST - 1 - g);

        always_ff @(posedge i_clk) begin
            logic signed [NW-1:0] xs;
            logic signed [NW-1:0] ys;
            if (i_ce) begin
                xs = NW'(r_x[g]) <<< (K - 1);
                ys = NW'(r_y[g]) <<< (K - 1);
                if (xs < QNW && ys < QNW && ys > -QNW) begin
                    r_x[g+1] <= r_x[g] <<< K;
                    r_y[g+1] <= r_y[g] <<< K;
                end else begin
                    r_x[g+1] <= r_x[g];
                    r_y[g+1] <= r_y[g];
                end
                r_z[g+1] <= r_z[g];
            end
        end
    end

    for (genvar g = 0; g < N_ITER; g++) begin : g_vec
        localparam t_cq ATN = t_cq'(atan_turn(g));
        localparam int  S   = VSTART + g;

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_z[S+1] <= (r_y[S] > 0) ? r_z[S] + ATN : r_z[S] - ATN;
            end
        end

        if (g < N_ITER - 1) begin : g_xy
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    if (r_y[S] > 0) begin
                        r_x[S+1] <= r_x[S] + (r_y[S] >>> g);
                        r_y[S+1] <= r_y[S] - (r_x[S] >>> g);
                    end else begin
                        r_x[S+1] <= r_x[S] - (r_y[S] >>> g);
                        r_y[S+1] <= r_y[S] + (r_x[S] >>> g);
                    end
                end
            end
        end
    end

    // binary angle back to 1e-7 degree, rounded half away from zero
    always_ff @(posedge i_clk) begin
        logic signed [32:0] s;
        logic [32:0]        m;
        logic [NUM_W-1:0]   sum;
        if (i_ce) begin
            s        = 33'(signed'(r_z[NORM_ST+N_ITER][TURN_W-1:0]));
            m        = s[32] ? 33'(-s) : 33'(s);
            r_neg[0] <= s[32];
            r_mag    <= m[MAG_W-1:0];
            r_neg[1] <= r_neg[0];
            r_prod   <= NUM_W'(r_mag) * NUM_W'(DEG_DEN);
            sum      = r_prod + (NUM_W'(1) << (FRAC_W - 1));
            if (r_zero[LAST-1]) begin
                r_bearing <= '0;
            end else if (r_neg[1]) begin
                r_bearing <= -signed'(sum[NUM_W-1:FRAC_W]);
            end else begin
                r_bearing <= signed'(sum[NUM_W-1:FRAC_W]);
            end
        end
    end

    assign o_valid   = r_v[LAST];
    assign o_bearing = r_bearing;

endmodule

FILE: src/initial_bearing.sv
// Initial great-circle bearing from point A to point B. Latitudes and longitudes are signed
// 1e-7 degree values; the bearing comes back in the same units, north zero, east positive,
// in -180..+180 degrees, and 0 when both points coincide in the computed components. The
// block takes one point pair every cycle while the output is not stalled and gives one word per
// pair, in order. The pipeline is a constant divider that turns the angles into binary angles,
// the rotation CORDIC for sine and cosine, three product stages, and the normalizer, vectoring
// CORDIC and scaling for the atan2. The whole pipeline advances together and holds while a
// finished word waits at the output.
module initial_bearing (
    input logic      i_clk,
    input logic      i_rst_n,
    ib_in_if.sink    i_in,
    ib_out_if.source o_out
);
    import ib_pkg::*;

    logic  ce;
    t_sang ang [LANES];
    logic  div_v, sc_v, pr_v;
    t_turn turn [LANES];
    t_trig trig [LANES];
    t_cq   px, py;

    assign ce         = !o_out.valid || o_out.ready;
    assign i_in.ready = ce;

    assign ang[LANE_LAT_A] = t_sang'(i_in.lat_a);
    assign ang[LANE_LAT_B] = t_sang'(i_in.lat_b);
    assign ang[LANE_DLON]  = t_sang'(i_in.lon_b) - t_sang'(i_in.lon_a);

    ib_turn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (i_in.valid),
        .i_ang   (ang),
        .o_valid (div_v),
        .o_turn  (turn)
    );

    ib_sincos u_sc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (div_v),
        .i_turn  (turn),
        .o_valid (sc_v),
        .o_trig  (trig)
    );

    ib_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (sc_v),
        .i_trig  (trig),
        .o_valid (pr_v),
        .o_x     (px),
        .o_y     (py)
    );

    ib_atan u_atan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ce      (ce),
        .i_valid   (pr_v),
        .i_x       (px),
        .i_y       (py),
        .o_valid   (o_out.valid),
        .o_bearing (o_out.bearing)
    );

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.bearing <= 32'sd1800000000 &&
                         o_out.bearing >= -32'sd1800000000))
        else $error("bearing out of range");

    a_rst_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out.valid)
        else $error("output valid right after reset");

    a_no_entry_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while pipeline stalled");

endmodule
